// ----- hw/rtl/yibd_pkg.sv -----
// ----------------------------------------------------------------------------
// yibd_pkg
// shared types, constants and helper functions for the ycbcr to indexed
// color converter with 4x4 ordered dither
// ----------------------------------------------------------------------------
package yibd_pkg;

  localparam int unsigned NumStages = 5;
  localparam int unsigned NumChan   = 3;

  // channel order in per-channel arrays
  localparam int unsigned ChR = 0;
  localparam int unsigned ChG = 1;
  localparam int unsigned ChB = 2;

  // palette mode codes
  localparam logic [1:0] Mode2x4x2 = 2'd0;
  localparam logic [1:0] Mode4x4x2 = 2'd1;
  localparam logic [1:0] Mode6x6x6 = 2'd2;
  localparam logic [1:0] ModeReset = Mode6x6x6;

  localparam int unsigned InDataW  = 32;
  localparam int unsigned OutDataW = 8;

  typedef logic [7:0]                 byte_t;
  typedef logic [NumChan-1:0][2:0]    lvl_t;   // levels minus one, per channel
  typedef logic signed [17:0]         term_t;

  // levels minus one for each channel
  function automatic lvl_t mode_lm1(logic [1:0] mode);
    lvl_t l;
    unique case (mode)
      Mode2x4x2: begin
        l[ChR] = 3'd1;
        l[ChG] = 3'd3;
        l[ChB] = 3'd1;
      end
      Mode4x4x2: begin
        l[ChR] = 3'd3;
        l[ChG] = 3'd3;
        l[ChB] = 3'd1;
      end
      default: begin
        l[ChR] = 3'd5;
        l[ChG] = 3'd5;
        l[ChB] = 3'd5;
      end
    endcase
    return l;
  endfunction

  function automatic logic [3:0] bayer4(logic [1:0] row, logic [1:0] col);
    logic [3:0] t;
    case ({row, col})
      4'h0: t = 4'd0;
      4'h1: t = 4'd8;
      4'h2: t = 4'd2;
      4'h3: t = 4'd10;
      4'h4: t = 4'd12;
      4'h5: t = 4'd4;
      4'h6: t = 4'd14;
      4'h7: t = 4'd6;
      4'h8: t = 4'd3;
      4'h9: t = 4'd11;
      4'ha: t = 4'd1;
      4'hb: t = 4'd9;
      4'hc: t = 4'd15;
      4'hd: t = 4'd7;
      4'he: t = 4'd13;
      default: t = 4'd5;
    endcase
    return t;
  endfunction

  // clip a pre-shift channel sum to a byte
  function automatic byte_t to_byte(logic signed [18:0] s);
    byte_t b;
    if (s[18]) begin
      b = 8'd0;
    end else if (s[17:16] != 2'd0) begin
      b = 8'hff;
    end else begin
      b = s[15:8];
    end
    return b;
  endfunction

  // dither offset (t-8)*step/16, truncated toward zero
  function automatic logic signed [8:0] dither_off(logic [3:0] t, logic [2:0] lm1);
    logic signed [13:0] step;
    logic signed [13:0] p;
    logic signed [13:0] a;
    logic signed [13:0] r;
    case (lm1)
      3'd1:    step = 14'sd255;
      3'd3:    step = 14'sd85;
      default: step = 14'sd51;
    endcase
    p = (14'($signed({1'b0, t})) - 14'sd8) * step;
    a = p[13] ? -p : p;
    r = a >>> 4;
    if (p[13]) begin
      r = -r;
    end
    return r[8:0];
  endfunction

endpackage

// ----- hw/rtl/yuv_to_indexed_bayer_dither_unit.sv -----
// ----------------------------------------------------------------------------
// yuv_to_indexed_bayer_dither_unit
// ycbcr pixel to palette index with bt601 conversion and 4x4 ordered dither
// ----------------------------------------------------------------------------
// throughput: one pixel per cycle while the output is not stalled, set by the five-stage pipeline
// a stalled output holds each stage that has no free slot behind it
// reset clears all stage valid bits and sets palette_mode to 6x6x6
module yuv_to_indexed_bayer_dither_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [1:0]                    cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // luma[7:0], chroma_blue[15:8], chroma_red[23:16], col_phase[25:24],
  // row_phase[27:26], zero[31:28]
  input  logic [yibd_pkg::InDataW-1:0]  s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // palette_index[7:0]
  output logic [yibd_pkg::OutDataW-1:0] m_axis_tdata
);
  import yibd_pkg::*;

  logic [1:0]           mode_q;
  logic [NumStages-1:0] valid_q;
  logic [NumStages-1:0] stage_rdy;
  lvl_t                 lm1;

  assign cfg_ready_o = 1'b1;
  assign lm1         = mode_lm1(mode_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeReset;
    end else if (cfg_valid_i) begin
      mode_q <= cfg_data_i;
    end
  end

  // stall chain
  always_comb begin
    stage_rdy[NumStages-1] = !valid_q[NumStages-1] || m_axis_tready;
    for (int i = NumStages - 2; i >= 0; i--) begin
      stage_rdy[i] = !valid_q[i] || stage_rdy[i+1];
    end
  end

  assign s_axis_tready = stage_rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (stage_rdy[0]) begin
        valid_q[0] <= s_axis_tvalid;
      end
      for (int i = 1; i < NumStages; i++) begin
        if (stage_rdy[i]) begin
          valid_q[i] <= valid_q[i-1];
        end
      end
    end
  end

  // stage 1: luma scale and chroma products
  byte_t             luma, cb, cr;
  logic [7:0]        y_off;
  logic signed [8:0] cb_s, cr_s;
  logic [16:0]       ys_d, ys_q;
  term_t [NumChan-1:0] k_d, k_q;
  logic [3:0]        t1_d, t1_q;

  assign luma = s_axis_tdata[7:0];
  assign cb   = s_axis_tdata[15:8];
  assign cr   = s_axis_tdata[23:16];
  assign y_off = (luma > 8'd16) ? (luma - 8'd16) : 8'd0;
  assign cb_s  = $signed({1'b0, cb}) - 9'sd128;
  assign cr_s  = $signed({1'b0, cr}) - 9'sd128;
  assign ys_d  = 17'(y_off) * 17'd298 + 17'd128;
  assign k_d[ChR] = term_t'(cr_s) * 18'sd409;
  assign k_d[ChG] = -(term_t'(cb_s) * 18'sd100) - term_t'(cr_s) * 18'sd208;
  assign k_d[ChB] = term_t'(cb_s) * 18'sd516;
  assign t1_d = bayer4(s_axis_tdata[27:26], s_axis_tdata[25:24]);

  always_ff @(posedge clk_i) begin
    if (stage_rdy[0]) begin
      ys_q <= ys_d;
      k_q  <= k_d;
      t1_q <= t1_d;
    end
  end

  // stage 2: channel sums clipped to bytes
  byte_t [NumChan-1:0] rgb_d, rgb_q;
  logic [3:0]          t2_q;

  always_comb begin
    for (int c = 0; c < NumChan; c++) begin
      rgb_d[c] = to_byte($signed({2'b00, ys_q}) + 19'(k_q[c]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_rdy[1]) begin
      rgb_q <= rgb_d;
      t2_q  <= t1_q;
    end
  end

  // stage 3: dither offset and clamp
  byte_t [NumChan-1:0] dith_d, dith_q;
  logic signed [9:0]   dsum [NumChan];

  always_comb begin
    for (int c = 0; c < NumChan; c++) begin
      dsum[c] = $signed({2'b00, rgb_q[c]}) + 10'(dither_off(t2_q, lm1[c]));
      if (dsum[c][9]) begin
        dith_d[c] = 8'd0;
      end else if (dsum[c][8]) begin
        dith_d[c] = 8'hff;
      end else begin
        dith_d[c] = dsum[c][7:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_rdy[2]) begin
      dith_q <= dith_d;
    end
  end

  // stage 4: quantize, n/255 as (n + 1 + n/256)/256
  logic [NumChan-1:0][2:0] lvl_d, lvl_q;
  logic [10:0]             qn   [NumChan];
  logic [10:0]             qsum [NumChan];

  always_comb begin
    for (int c = 0; c < NumChan; c++) begin
      qn[c]    = 11'(dith_q[c]) * 11'(lm1[c]) + 11'd127;
      qsum[c]  = qn[c] + 11'd1 + 11'(qn[c][10:8]);
      lvl_d[c] = qsum[c][10:8];
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_rdy[3]) begin
      lvl_q <= lvl_d;
    end
  end

  // stage 5: palette index
  logic [7:0] idx_d, idx_q;

  always_comb begin
    unique case (mode_q)
      Mode2x4x2, Mode4x4x2: begin
        idx_d = {2'b00, lvl_q[ChR][2:0], 3'b000} + {4'b0000, lvl_q[ChG], 1'b0}
              + {5'b00000, lvl_q[ChB]};
      end
      default: begin
        idx_d = 8'(lvl_q[ChR]) * 8'd36 + 8'(lvl_q[ChG]) * 8'd6 + 8'(lvl_q[ChB]);
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (stage_rdy[4]) begin
      idx_q <= idx_d;
    end
  end

  assign m_axis_tvalid = valid_q[NumStages-1];
  assign m_axis_tdata  = idx_q;

  a_in_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> valid_q[0])
    else $error("accepted beat did not enter stage 1");

  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[0] && !stage_rdy[1] |=> valid_q[0] && $stable(t1_q))
    else $error("stalled stage 1 lost its beat");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata < 8'd216)
    else $error("palette index out of range");

  a_small_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (mode_q == Mode2x4x2 || mode_q == Mode4x4x2)
      |-> m_axis_tdata < 8'd32)
    else $error("palette index too large for small palette");

endmodule

// ----- sim/yuv_to_indexed_bayer_dither_unit_tb.sv -----
// ----------------------------------------------------------------------------
// yuv_to_indexed_bayer_dither_unit_tb
// streams pixels through the ycbcr to palette index converter in every
// palette mode, predicts each index with a behavioral bt601 plus ordered
// dither calculation and compares the output beats in order, with random
// idle cycles on both sides and one long output stall
// ----------------------------------------------------------------------------
module yuv_to_indexed_bayer_dither_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import yibd_pkg::*;

  localparam logic [1:0] ModeSpare = 2'd3;
  localparam int unsigned NumPhases = 8;
  localparam int unsigned PhaseItems = 80;

  typedef struct packed {
    logic [1:0] row;
    logic [1:0] col;
    logic [7:0] cr;
    logic [7:0] cb;
    logic [7:0] luma;
  } pixel_t;

  class dither_scoreboard;
    logic [7:0] index_q[$];
    logic [1:0] mode;
    int         errors;
    int         thr[4][4];

    function new();
      mode   = ModeReset;
      errors = 0;
      thr    = '{'{0, 8, 2, 10}, '{12, 4, 14, 6}, '{3, 11, 1, 9}, '{15, 7, 13, 5}};
    endfunction

    function int clip_byte(int s);
      if (s < 0) return 0;
      s = s >>> 8;
      return (s > 255) ? 255 : s;
    endfunction

    function int level_of(int v, int lm1, int t);
      int offs;
      int x;
      offs = ((t - 8) * (255 / lm1)) / 16;
      x = v + offs;
      if (x < 0) x = 0;
      else if (x > 255) x = 255;
      return (x * lm1 + 127) / 255;
    endfunction

    function logic [7:0] index_of(pixel_t p);
      int ys, cb, cr, t;
      int lr, lg, lb;
      int qr, qg, qb;
      case (mode)
        Mode2x4x2: begin
          lr = 1; lg = 3; lb = 1;
        end
        Mode4x4x2: begin
          lr = 3; lg = 3; lb = 1;
        end
        default: begin
          lr = 5; lg = 5; lb = 5;
        end
      endcase
      ys = int'(p.luma) - 16;
      if (ys < 0) ys = 0;
      ys = 298 * ys + 128;
      cb = int'(p.cb) - 128;
      cr = int'(p.cr) - 128;
      t  = thr[p.row][p.col];
      qr = level_of(clip_byte(ys + 409 * cr), lr, t);
      qg = level_of(clip_byte(ys - 100 * cb - 208 * cr), lg, t);
      qb = level_of(clip_byte(ys + 516 * cb), lb, t);
      return 8'(qr * (lg + 1) * (lb + 1) + qg * (lb + 1) + qb);
    endfunction

    task flag_mismatch(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    function void note_pixel(pixel_t p);
      index_q.push_back(index_of(p));
    endfunction

    task check_index(logic [7:0] got);
      logic [7:0] want;
      if (index_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected beat, palette_index %0d", got));
      end else begin
        want = index_q.pop_front();
        if (got !== want) begin
          flag_mismatch($sformatf("palette_index got %0d want %0d", got, want));
        end
      end
    endtask
  endclass

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_data_i    = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;

  dither_scoreboard sb = new();
  bit send_idle   = 1'b1;
  bit recv_idle   = 1'b1;
  int hold_cycles = 0;

  yuv_to_indexed_bayer_dither_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #2 clk_i = ~clk_i;

  task automatic send_pixel(pixel_t p);
    int gap;
    gap = send_idle ? $urandom_range(0, 18) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, p.row, p.col, p.cr, p.cb, p.luma};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_pixel(p);
  endtask

  task automatic write_mode(logic [1:0] m);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= m;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.mode = m;
  endtask

  function automatic logic [7:0] rail_byte();
    case ($urandom_range(0, 2))
      0:       return 8'($urandom_range(0, 20));
      1:       return 8'($urandom_range(235, 255));
      default: return 8'($urandom_range(118, 138));
    endcase
  endfunction

  function automatic pixel_t rand_pixel();
    pixel_t p;
    p = pixel_t'($urandom);
    case ($urandom_range(0, 3))
      2: begin
        p.luma = rail_byte();
        p.cb   = rail_byte();
        p.cr   = rail_byte();
      end
      3: begin
        // near-gray pixels
        p.cb = 8'($urandom_range(124, 132));
        p.cr = 8'($urandom_range(124, 132));
      end
      default: ;
    endcase
    return p;
  endfunction

  // output side
  initial begin
    int n;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_cycles > 0) begin
        n = hold_cycles;
        hold_cycles = 0;
      end else begin
        n = recv_idle ? $urandom_range(0, 18) : 0;
      end
      if (n > 0) begin
        m_axis_tready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      sb.check_index(m_axis_tdata);
    end
  end

  initial begin
    #1ms;
    $display("yuv_to_indexed_bayer_dither_unit_tb: FAIL");
    $finish;
  end

  initial begin
    logic [23:0] rails [8];
    logic [1:0]  phase_mode [NumPhases];
    pixel_t      p;
    int          waited;
    rails = '{24'h000000, 24'hffffff, 24'h80800f, 24'h808010,
              24'h0000ff, 24'hff00ff, 24'h00ff00, 24'h8080eb};
    phase_mode = '{Mode6x6x6, Mode2x4x2, Mode4x4x2, ModeSpare,
                   Mode6x6x6, Mode2x4x2, ModeSpare, Mode4x4x2};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // every dither phase over a luma ramp, then the rails
    for (int k = 0; k < 16; k++) begin
      p.luma = 8'(k * 17);
      p.cb   = 8'd128;
      p.cr   = 8'd128;
      p.col  = 2'(k);
      p.row  = 2'(k >> 2);
      send_pixel(p);
    end
    for (int k = 0; k < 8; k++) begin
      {p.cr, p.cb, p.luma} = rails[k];
      p.col = 2'(k);
      p.row = 2'(3 - k);
      send_pixel(p);
    end

    for (int ph = 0; ph < NumPhases; ph++) begin
      if (ph > 0) begin
        s_axis_tvalid <= 1'b0;
        while (sb.index_q.size() != 0) @(posedge clk_i);
        repeat (8) @(posedge clk_i);
        write_mode(phase_mode[ph]);
      end
      send_idle = !(ph % 4 == 3 || ph == 2);
      recv_idle = !(ph % 4 == 3 || ph == 5);
      if (ph == 2) hold_cycles = 60;
      repeat (PhaseItems) send_pixel(rand_pixel());
    end
    s_axis_tvalid <= 1'b0;

    waited = 0;
    while (sb.index_q.size() != 0 && waited < 5000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (20) @(posedge clk_i);
    while (sb.index_q.size() != 0) begin
      sb.flag_mismatch($sformatf("missing beat, palette_index %0d", sb.index_q.pop_front()));
    end
    if (sb.errors == 0) begin
      $display("yuv_to_indexed_bayer_dither_unit_tb: PASS");
    end else begin
      $display("yuv_to_indexed_bayer_dither_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
